FILE: hw/rtl/gr2rc_pkg.sv
package gr2rc_pkg;

    localparam int NUM_CHAN = 6;
    localparam int CHAN_W   = 12;
    localparam int FRAC_W   = 8;
    localparam int STATE_W  = CHAN_W + FRAC_W;
    localparam int GAIN_W   = 9;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_PULSE_MIN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_MID   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_MAX   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SMOOTH_GAIN = 2'd3;

    localparam logic [BYTE_W-1:0] AXIS_LOW  = 8'h00;
    localparam logic [BYTE_W-1:0] AXIS_MID  = 8'h7F;
    localparam logic [BYTE_W-1:0] AXIS_HIGH = 8'hFF;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 9'd256;

    localparam logic [CHAN_W-1:0] RST_PULSE_MIN   = 12'd1000;
    localparam logic [CHAN_W-1:0] RST_PULSE_MID   = 12'd1500;
    localparam logic [CHAN_W-1:0] RST_PULSE_MAX   = 12'd2000;
    localparam logic [GAIN_W-1:0] RST_SMOOTH_GAIN = 9'd128;
    localparam logic [CHAN_W-1:0] RST_TARGET      = 12'd1000;
    localparam logic [STATE_W-1:0] RST_STATE      = {RST_TARGET, {FRAC_W{1'b0}}};

    typedef logic [CHAN_W-1:0] t_chan;
    typedef t_chan [NUM_CHAN-1:0] t_chan_arr;

    typedef struct packed {
        logic [BYTE_W-1:0] axis_x;
        logic [BYTE_W-1:0] axis_y;
        logic [BYTE_W-1:0] buttons_upper;
        logic [BYTE_W-1:0] buttons_lower;
    } t_item;

    typedef struct packed {
        t_chan             pulse_min;
        t_chan             pulse_mid;
        t_chan             pulse_max;
        logic [GAIN_W-1:0] smooth_gain;
    } t_cfg;

endpackage

FILE: hw/rtl/gr2rc_if.sv
interface gr2rc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] axis_x;
    logic [7:0] axis_y;
    logic [7:0] buttons_upper;
    logic [7:0] buttons_lower;

    modport source (output valid, axis_x, axis_y, buttons_upper, buttons_lower, input ready);
    modport sink (input valid, axis_x, axis_y, buttons_upper, buttons_lower, output ready);
endinterface

interface gr2rc_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] chan_0;
    logic [11:0] chan_1;
    logic [11:0] chan_2;
    logic [11:0] chan_3;
    logic [11:0] chan_4;
    logic [11:0] chan_5;

    modport source (output valid, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5,
                    input ready);
    modport sink (input valid, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5,
                  output ready);
endinterface

FILE: hw/rtl/gr2rc_regs.sv
module gr2rc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gr2rc_pkg::ADDR_W-1:0] paddr,
    input  logic [gr2rc_pkg::DATA_W-1:0] pwdata,
    output logic [gr2rc_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output gr2rc_pkg::t_cfg              o_cfg
);
    import gr2rc_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_min   <= RST_PULSE_MIN;
            r_cfg.pulse_mid   <= RST_PULSE_MID;
            r_cfg.pulse_max   <= RST_PULSE_MAX;
            r_cfg.smooth_gain <= RST_SMOOTH_GAIN;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PULSE_MIN:   r_cfg.pulse_min   <= pwdata[CHAN_W-1:0];
                REG_PULSE_MID:   r_cfg.pulse_mid   <= pwdata[CHAN_W-1:0];
                REG_PULSE_MAX:   r_cfg.pulse_max   <= pwdata[CHAN_W-1:0];
                REG_SMOOTH_GAIN: r_cfg.smooth_gain <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PULSE_MIN:   prdata = DATA_W'(r_cfg.pulse_min);
            REG_PULSE_MID:   prdata = DATA_W'(r_cfg.pulse_mid);
            REG_PULSE_MAX:   prdata = DATA_W'(r_cfg.pulse_max);
            REG_SMOOTH_GAIN: prdata = DATA_W'(r_cfg.smooth_gain);
            default:         prdata = '0;
        endcase
    end
endmodule

FILE: hw/rtl/gr2rc_target.sv
module gr2rc_target (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  gr2rc_pkg::t_item     i_item,
    input  gr2rc_pkg::t_cfg      i_cfg,
    output gr2rc_pkg::t_chan_arr o_next
);
    import gr2rc_pkg::*;

    t_chan_arr r_held;
    t_chan_arr n_held;

    function automatic t_chan axis_pick(input logic [BYTE_W-1:0] b, input t_chan lo,
                                        input t_chan mid, input t_chan hi,
                                        input t_chan old);
        t_chan v;
        priority case (b)
            AXIS_LOW:  v = lo;
            AXIS_MID:  v = mid;
            AXIS_HIGH: v = hi;
            default:   v = old;
        endcase
        return v;
    endfunction

    always_comb begin
        n_held    = r_held;
        n_held[0] = axis_pick(i_item.axis_x, i_cfg.pulse_min, i_cfg.pulse_mid,
                              i_cfg.pulse_max, r_held[0]);
        // y stick is inverted
        n_held[1] = axis_pick(i_item.axis_y, i_cfg.pulse_max, i_cfg.pulse_mid,
                              i_cfg.pulse_min, r_held[1]);

        priority if (i_item.buttons_upper[4]) begin
            n_held[2] = i_cfg.pulse_min;
        end else if (i_item.buttons_upper[7]) begin
            n_held[2] = i_cfg.pulse_max;
        end else begin
            n_held[2] = i_cfg.pulse_mid;
        end

        priority if (i_item.buttons_upper[5]) begin
            n_held[3] = i_cfg.pulse_max;
        end else if (i_item.buttons_upper[6]) begin
            n_held[3] = i_cfg.pulse_min;
        end else begin
            n_held[3] = i_cfg.pulse_mid;
        end

        if (i_item.buttons_lower[0]) begin
            n_held[4] = i_cfg.pulse_min;
        end else if (i_item.buttons_lower[2]) begin
            n_held[4] = i_cfg.pulse_max;
        end

        if (i_item.buttons_lower[1]) begin
            n_held[5] = i_cfg.pulse_min;
        end else if (i_item.buttons_lower[3]) begin
            n_held[5] = i_cfg.pulse_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= {NUM_CHAN{RST_TARGET}};
        end else if (i_en) begin
            r_held <= n_held;
        end
    end

    assign o_next = n_held;
endmodule

FILE: hw/rtl/gr2rc_smooth.sv
module gr2rc_smooth (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  gr2rc_pkg::t_chan             i_target,
    input  logic [gr2rc_pkg::GAIN_W-1:0] i_gain,
    output gr2rc_pkg::t_chan             o_chan
);
    import gr2rc_pkg::*;

    localparam int PROD_W = STATE_W + GAIN_W;

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic [GAIN_W-1:0]  w_g;
    logic [GAIN_W-1:0]  w_inv;
    logic [PROD_W-1:0]  w_new;
    logic [PROD_W-1:0]  w_old;
    logic [PROD_W-1:0]  w_acc;

    // gain above one saturates to one
    assign w_g     = i_gain[GAIN_W-1] ? GAIN_ONE : i_gain;
    assign w_inv   = GAIN_ONE - w_g;
    assign w_new   = PROD_W'({i_target, {FRAC_W{1'b0}}}) * PROD_W'(w_g);
    assign w_old   = PROD_W'(r_state) * PROD_W'(w_inv);
    assign w_acc   = w_new + w_old;
    assign n_state = w_acc[FRAC_W +: STATE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RST_STATE;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_chan = n_state[STATE_W-1:FRAC_W];
endmodule

FILE: hw/rtl/gamepad_report_to_rc_channels.sv
// latency: an accepted request goes into the input register, its result then into the
// result register once that one is empty or read; throughput: one request per cycle
// while not back-pressured, set by the single compute stage between the two registers
// reset: synchronous active-low i_rst_n clears both valid flags, loads the config
// registers with their defaults and the held targets and filter states with 1000
module gamepad_report_to_rc_channels #(
    parameter int SMOOTHED_CHANNELS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    gr2rc_in_if.sink                     i_in,
    gr2rc_out_if.source                  o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gr2rc_pkg::ADDR_W-1:0] paddr,
    input  logic [gr2rc_pkg::DATA_W-1:0] pwdata,
    output logic [gr2rc_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import gr2rc_pkg::*;

    t_cfg      w_cfg;
    t_item     r_item;
    logic      r_in_vld;
    logic      r_out_vld;
    t_chan_arr r_chan;
    t_chan_arr w_next;
    t_chan_arr w_res;
    logic      w_adv;
    logic      w_load;

    gr2rc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign w_load     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.axis_x        <= i_in.axis_x;
            r_item.axis_y        <= i_in.axis_y;
            r_item.buttons_upper <= i_in.buttons_upper;
            r_item.buttons_lower <= i_in.buttons_lower;
        end
    end

    gr2rc_target u_target (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    for (genvar gi = 0; gi < NUM_CHAN; gi++) begin : g_chan
        if (gi < SMOOTHED_CHANNELS) begin : g_smooth
            gr2rc_smooth u_smooth (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_adv),
                .i_target (w_next[gi]),
                .i_gain   (w_cfg.smooth_gain),
                .o_chan   (w_res[gi])
            );
        end else begin : g_direct
            assign w_res[gi] = w_next[gi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || o_out.ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_chan <= w_res;
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.chan_0 = r_chan[0];
    assign o_out.chan_1 = r_chan[1];
    assign o_out.chan_2 = r_chan[2];
    assign o_out.chan_3 = r_chan[3];
    assign o_out.chan_4 = r_chan[4];
    assign o_out.chan_5 = r_chan[5];

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_in_vld)
        else $error("accepted request did not reach input register");

    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("computed result did not reach result register");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_vld && !r_out_vld)
        else $error("valid flags not cleared by reset");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gr2rc_pkg::*;

    localparam int SMOOTHED = 4;
    localparam int CYCLE_LIMIT = 500_000;

    localparam t_item DIRECTED [18] = '{
        32'h00FF_1001, 32'h7F7F_0000, 32'hFF00_8004, 32'hFF00_9005,
        32'h8001_2002, 32'h7FFE_4008, 32'h007F_600A, 32'hFE80_F0F0,
        32'h01FF_00FF, 32'hFFFF_FF00, 32'h0000_0F0F, 32'h7F00_A00C,
        32'hAA55_5003, 32'h55AA_C000, 32'hFF7F_0004, 32'h00FF_8008,
        32'h7F7F_0000, 32'h7F7F_0000
    };

    class chan_scoreboard;
        t_cfg               cfg;
        t_chan              held [NUM_CHAN];
        logic [STATE_W-1:0] filt [NUM_CHAN];
        t_chan_arr          expected_q [$];
        int                 errors;

        function new();
            cfg.pulse_min   = RST_PULSE_MIN;
            cfg.pulse_mid   = RST_PULSE_MID;
            cfg.pulse_max   = RST_PULSE_MAX;
            cfg.smooth_gain = RST_SMOOTH_GAIN;
            foreach (held[i]) begin
                held[i] = RST_TARGET;
                filt[i] = RST_STATE;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_PULSE_MIN:   cfg.pulse_min   = val[CHAN_W-1:0];
                REG_PULSE_MID:   cfg.pulse_mid   = val[CHAN_W-1:0];
                REG_PULSE_MAX:   cfg.pulse_max   = val[CHAN_W-1:0];
                REG_SMOOTH_GAIN: cfg.smooth_gain = val[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
            case (idx)
                REG_PULSE_MIN:   return DATA_W'(cfg.pulse_min);
                REG_PULSE_MID:   return DATA_W'(cfg.pulse_mid);
                REG_PULSE_MAX:   return DATA_W'(cfg.pulse_max);
                REG_SMOOTH_GAIN: return DATA_W'(cfg.smooth_gain);
                default:         return '0;
            endcase
        endfunction

        function t_chan axis_pick(logic [BYTE_W-1:0] b, t_chan lo, t_chan hi, t_chan old);
            if (b == AXIS_LOW) return lo;
            if (b == AXIS_MID) return cfg.pulse_mid;
            if (b == AXIS_HIGH) return hi;
            return old;
        endfunction

        // 12.8 first-order filter, gain saturates at one
        function logic [STATE_W-1:0] filter_step(t_chan target, logic [STATE_W-1:0] prev);
            logic [31:0] g;
            logic [31:0] acc;
            g = (cfg.smooth_gain > GAIN_ONE) ? 32'(GAIN_ONE) : 32'(cfg.smooth_gain);
            acc = ((32'(target) << FRAC_W) * g) + (32'(prev) * (32'(GAIN_ONE) - g));
            return acc[FRAC_W +: STATE_W];
        endfunction

        function void note_request(t_item it);
            t_chan_arr res;
            held[0] = axis_pick(it.axis_x, cfg.pulse_min, cfg.pulse_max, held[0]);
            held[1] = axis_pick(it.axis_y, cfg.pulse_max, cfg.pulse_min, held[1]);

            if (it.buttons_upper[4]) held[2] = cfg.pulse_min;
            else if (it.buttons_upper[7]) held[2] = cfg.pulse_max;
            else held[2] = cfg.pulse_mid;

            if (it.buttons_upper[5]) held[3] = cfg.pulse_max;
            else if (it.buttons_upper[6]) held[3] = cfg.pulse_min;
            else held[3] = cfg.pulse_mid;

            if (it.buttons_lower[0]) held[4] = cfg.pulse_min;
            else if (it.buttons_lower[2]) held[4] = cfg.pulse_max;

            if (it.buttons_lower[1]) held[5] = cfg.pulse_min;
            else if (it.buttons_lower[3]) held[5] = cfg.pulse_max;

            for (int i = 0; i < NUM_CHAN; i++) begin
                if (i < SMOOTHED) begin
                    filt[i] = filter_step(held[i], filt[i]);
                    res[i] = filt[i][FRAC_W +: CHAN_W];
                end else begin
                    res[i] = held[i];
                end
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(t_chan_arr got);
            t_chan_arr want;
            if (expected_q.size() == 0) begin
                $error("result with no request pending: chan_0 %0d", got[0]);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            for (int i = 0; i < NUM_CHAN; i++) begin
                if (got[i] !== want[i]) begin
                    $error("chan_%0d: expected %0d, got %0d", i, want[i], got[i]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    bit                burst_mode = 1'b0;
    int unsigned       cycle_count = 0;
    chan_scoreboard    sb = new();

    gr2rc_in_if  in_bus ();
    gr2rc_out_if out_bus ();

    gamepad_report_to_rc_channels #(
        .SMOOTHED_CHANNELS(SMOOTHED)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            sb.note_request({in_bus.axis_x, in_bus.axis_y,
                             in_bus.buttons_upper, in_bus.buttons_lower});
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            sb.check_result({out_bus.chan_5, out_bus.chan_4, out_bus.chan_3,
                             out_bus.chan_2, out_bus.chan_1, out_bus.chan_0});
        end
    end

    // mostly short gaps, a few long ones, none in burst phases
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] random_axis();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return AXIS_LOW;
        if (r < 4) return AXIS_MID;
        if (r < 6) return AXIS_HIGH;
        return BYTE_W'($urandom);
    endfunction

    function automatic t_item random_report();
        t_item it;
        it.axis_x        = random_axis();
        it.axis_y        = random_axis();
        it.buttons_upper = BYTE_W'($urandom);
        it.buttons_lower = BYTE_W'($urandom);
        return it;
    endfunction

    // result sink with random backpressure
    initial begin
        int n;
        out_bus.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_bus.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(t_item it);
        int n;
        n = pick_gap();
        if (n > 0) begin
            in_bus.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.axis_x        <= it.axis_x;
        in_bus.axis_y        <= it.axis_y;
        in_bus.buttons_upper <= it.buttons_upper;
        in_bus.buttons_lower <= it.buttons_lower;
        do @(posedge i_clk); while (!in_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read_check(logic [REG_IDX_W-1:0] idx);
        logic [DATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== sb.reg_value(idx)) begin
            $error("prdata reg %0d: expected %0d, got %0d", idx, sb.reg_value(idx), got);
            sb.errors++;
        end
    endtask

    task automatic run_phase(t_chan lo, t_chan mid, t_chan hi,
                             logic [GAIN_W-1:0] gain, int count, bit burst);
        drain();
        reg_write(REG_PULSE_MIN, DATA_W'(lo));
        reg_write(REG_PULSE_MID, DATA_W'(mid));
        reg_write(REG_PULSE_MAX, DATA_W'(hi));
        reg_write(REG_SMOOTH_GAIN, DATA_W'(gain));
        reg_read_check(REG_PULSE_MIN);
        reg_read_check(REG_PULSE_MID);
        reg_read_check(REG_PULSE_MAX);
        reg_read_check(REG_SMOOTH_GAIN);
        burst_mode = burst;
        repeat (count) send_request(random_report());
    endtask

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_bus.valid         = 1'b0;
        in_bus.axis_x        = '0;
        in_bus.axis_y        = '0;
        in_bus.buttons_upper = '0;
        in_bus.buttons_lower = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of the registers
        reg_read_check(REG_PULSE_MIN);
        reg_read_check(REG_PULSE_MID);
        reg_read_check(REG_PULSE_MAX);
        reg_read_check(REG_SMOOTH_GAIN);

        foreach (DIRECTED[i]) send_request(DIRECTED[i]);

        run_phase(12'd1000, 12'd1500, 12'd2000, 9'd256, 110, 1'b1);
        run_phase(12'd0, 12'd2048, 12'd4095, 9'd128, 110, 1'b0);
        run_phase(12'd4095, 12'd0, 12'd0, 9'd1, 110, 1'b0);
        run_phase(12'd0, 12'd4095, 12'd4095, 9'd0, 100, 1'b0);
        run_phase(12'd2000, 12'd1000, 12'd3000, 9'd511, 110, 1'b0);
        run_phase(12'd100, 12'd200, 12'd300, 9'd300, 100, 1'b0);
        run_phase(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                  GAIN_W'($urandom_range(0, 256)), 120, $urandom_range(0, 3) == 0);
        run_phase(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                  GAIN_W'($urandom_range(0, 256)), 120, $urandom_range(0, 3) == 0);
        drain();
        repeat (8) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
